>>> sv/sira_pkg.sv
// Shared constants, types and the digit-to-character function of the radix text converter.
package sira_pkg;

  localparam int VALUE_BITS = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int BCNT_W     = $clog2(VALUE_BITS);
  localparam int DCNT_W     = $clog2(VALUE_BITS + 1);
  localparam int DEC_DIGITS = 10;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV_STEP,
    S_PUSH,
    S_SIGN,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PUSH,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_BIT_DONE,
    COND_MAG_ZERO,
    COND_LAST_DIGIT
  } cond_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_OUT,
    STALL_OUT_IF_NEG
  } stall_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    stall_t stall;
    step_t  t_true;
    step_t  t_false;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic bit_done;
    logic mag_zero;
    logic last_digit;
    logic out_free;
    logic neg;
  } status_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(DEC_DIGITS)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

>>> sv/signed_integer_to_radix_ascii_unit.sv
// Top level: converts a signed integer to ASCII text in a configurable base.
//
// The input stream carries one signed integer per word. The output stream
// returns its text one ASCII character per word, most significant digit
// first, led by a minus sign for negative values, with out_tlast on the
// final character. The base is written through cfg_we and cfg_wdata;
// values below 2 or above 36 saturate, and reset selects base sixteen.
// Each digit takes one division by the base in a shift-subtract unit that
// retires one quotient bit per cycle. An item passes through the accept
// step, one division per digit, one sign step that also loads the minus
// sign, and one emit step per digit. One item is worked on at a time;
// in_tready is high only while the sequencer is idle and reset is released.
// A stalled receiver holds the output register and the sequencer waits in
// place. Reset empties the digit stack and the output register and
// returns the sequencer to idle.
module signed_integer_to_radix_ascii_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sira_pkg::RADIX_W-1:0]       cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sira_pkg::VALUE_BITS-1:0]    in_tdata,   // value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // character, zero pad
  output logic                               out_tlast   // last
);
  import sira_pkg::*;

  ctrl_t                 ctrl;
  status_t               status;

  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    radix_nxt;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [BCNT_W-1:0]     bcnt_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [DIGIT_W-1:0]    dstk_r [VALUE_BITS];

  logic                  out_tvalid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [RADIX_W:0]      rem_sh;
  logic                  q_bit;
  logic [RADIX_W-1:0]    rem_nxt;
  logic                  out_free;

  sira_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    status.in_valid   = in_tvalid;
    status.bit_done   = (bcnt_r == '0);
    status.mag_zero   = (mag_r == '0);
    status.last_digit = (dcnt_r == DCNT_W'(1));
    status.out_free   = out_free;
    status.neg        = neg_r;
  end

  always_comb begin
    if (cfg_wdata < RADIX_MIN) begin
      radix_nxt = RADIX_MIN;
    end else if (cfg_wdata > RADIX_MAX) begin
      radix_nxt = RADIX_MAX;
    end else begin
      radix_nxt = cfg_wdata;
    end
  end

  always_comb begin
    rem_sh  = {rem_r, mag_r[VALUE_BITS-1]};
    q_bit   = (rem_sh >= {1'b0, radix_r});
    rem_nxt = q_bit ? RADIX_W'(rem_sh - {1'b0, radix_r}) : rem_sh[RADIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= radix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (in_tvalid) begin
          neg_r <= in_tdata[VALUE_BITS-1];
          mag_r <= in_tdata[VALUE_BITS-1] ? (~in_tdata + VALUE_BITS'(1)) : in_tdata;
        end
      end
      OP_DIV_INIT: begin
        rem_r  <= '0;
        bcnt_r <= BCNT_W'(VALUE_BITS - 1);
      end
      OP_DIV_STEP: begin
        rem_r  <= rem_nxt;
        mag_r  <= {mag_r[VALUE_BITS-2:0], q_bit};
        bcnt_r <= bcnt_r - BCNT_W'(1);
      end
      OP_PUSH: begin
        for (int i = VALUE_BITS - 1; i > 0; i--) begin
          dstk_r[i] <= dstk_r[i-1];
        end
        dstk_r[0] <= DIGIT_W'(rem_r);
      end
      OP_SIGN: begin
      end
      OP_EMIT: begin
        if (ctrl.go) begin
          for (int i = 0; i < VALUE_BITS - 1; i++) begin
            dstk_r[i] <= dstk_r[i+1];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (ctrl.op == OP_PUSH) begin
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end else if (ctrl.op == OP_EMIT && ctrl.go) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.op == OP_SIGN && ctrl.go && neg_r) begin
      out_tvalid_r <= 1'b1;
      out_char_r   <= CHAR_MINUS;
      out_last_r   <= 1'b0;
    end else if (ctrl.op == OP_EMIT && ctrl.go) begin
      out_tvalid_r <= 1'b1;
      out_char_r   <= digit_char(dstk_r[0]);
      out_last_r   <= (dcnt_r == DCNT_W'(1));
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign in_tready  = rst_n && (ctrl.op == OP_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    radix_r >= RADIX_MIN && radix_r <= RADIX_MAX)
    else $error("Radix register left the range two to thirty-six.");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> (dcnt_r != '0))
    else $error("Character emitted from an empty digit stack.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("New word accepted while a conversion is under way.");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= DCNT_W'(VALUE_BITS))
    else $error("Digit stack overflowed.");

endmodule

>>> sv/sira_seq.sv
// Microcode sequencer: program table, step counter and conditional jumps.
module sira_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  sira_pkg::status_t status,
  output sira_pkg::ctrl_t   ctrl
);
  import sira_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   cond_ok;
  logic   hold;

  function automatic uword_t rom(input step_t s);
    uword_t w;
    unique case (s)
      S_IDLE:     w = '{OP_IDLE,     COND_IN_VALID,   STALL_NONE,       S_DIV_INIT, S_IDLE};
      S_DIV_INIT: w = '{OP_DIV_INIT, COND_ALWAYS,     STALL_NONE,       S_DIV_STEP, S_DIV_STEP};
      S_DIV_STEP: w = '{OP_DIV_STEP, COND_BIT_DONE,   STALL_NONE,       S_PUSH,     S_DIV_STEP};
      S_PUSH:     w = '{OP_PUSH,     COND_MAG_ZERO,   STALL_NONE,       S_SIGN,     S_DIV_INIT};
      S_SIGN:     w = '{OP_SIGN,     COND_ALWAYS,     STALL_OUT_IF_NEG, S_EMIT,     S_EMIT};
      S_EMIT:     w = '{OP_EMIT,     COND_LAST_DIGIT, STALL_OUT,        S_IDLE,     S_EMIT};
      default:    w = '{OP_IDLE,     COND_ALWAYS,     STALL_NONE,       S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    uw = rom(step_r);
    unique case (uw.cond)
      COND_ALWAYS:     cond_ok = 1'b1;
      COND_IN_VALID:   cond_ok = status.in_valid;
      COND_BIT_DONE:   cond_ok = status.bit_done;
      COND_MAG_ZERO:   cond_ok = status.mag_zero;
      COND_LAST_DIGIT: cond_ok = status.last_digit;
      default:         cond_ok = 1'b1;
    endcase
    unique case (uw.stall)
      STALL_NONE:       hold = 1'b0;
      STALL_OUT:        hold = !status.out_free;
      STALL_OUT_IF_NEG: hold = status.neg && !status.out_free;
      default:          hold = 1'b0;
    endcase
    step_nxt = hold ? step_r : (cond_ok ? uw.t_true : uw.t_false);
    ctrl.op  = uw.op;
    ctrl.go  = !hold;
  end

endmodule
